[design/mpp_pkg.sv]
// ----------------------------------------------------------------------------
// mpp_pkg
// Shared widths, register indexes, pole pair codes and pipeline word types
// for the magnet pole pair force block.
// ----------------------------------------------------------------------------
package mpp_pkg;

    // field widths
    localparam int COORD_W  = 16;
    localparam int VEC_W    = 48;
    localparam int QUAT_W   = 64;
    localparam int STR_W    = 16;
    localparam int CFG_W    = 16;
    localparam int FORCE_W  = 20;
    localparam int FORCE3_W = 60;
    localparam int IN_W     = 448;
    localparam int OUT_W    = 160;
    localparam int USER_W   = 3;

    // internal arithmetic widths
    localparam int KMAG_W   = 46;
    localparam int PROD_W   = 62;
    localparam int ROOT_W   = 19;
    localparam int DIST_W   = 20;
    localparam int CUBE_W   = 60;
    localparam int QUOT_W   = 20;
    localparam int SCALE_SH = 8;

    // configuration register indexes
    localparam logic [0:0] CFG_FORCE_GAIN = 1'b0;
    localparam logic [0:0] CFG_SOFTENING  = 1'b1;

    localparam logic [CFG_W-1:0] FORCE_GAIN_RST = 16'd1280;
    localparam logic [CFG_W-1:0] SOFTENING_RST  = 16'd26;

    // pole pair codes (pole of a, pole of b)
    localparam logic [1:0] PAIR_SS = 2'd0;
    localparam logic [1:0] PAIR_NS = 2'd1;
    localparam logic [1:0] PAIR_SN = 2'd2;
    localparam logic [1:0] PAIR_NN = 2'd3;

    // force clip limits (magnitudes)
    localparam logic [FORCE_W-1:0] FORCE_POS_LIM = 20'd524287;
    localparam logic [FORCE_W-1:0] FORCE_NEG_LIM = 20'd524288;

    // side data ahead of the distance stage
    typedef struct packed {
        logic [1:0]        pair;
        logic              sneg;
        logic [KMAG_W-1:0] kmag;
    } pre_t;

    // side data carried alongside the distance and divide stages
    typedef struct packed {
        logic [1:0]       pair;
        logic [2:0]       neg;
        logic [VEC_W-1:0] pa;
        logic [VEC_W-1:0] pb;
    } side_t;

endpackage

[design/magnet_pair_pole_forces.sv]
// ----------------------------------------------------------------------------
// magnet_pair_pole_forces
// Pole forces between two bar magnets: four pole pair result words per
// input word, in order SS, NS, SN, NN.
// ----------------------------------------------------------------------------
// Each input word is held while its four pole pairs are issued into one
// force pipeline, one pair per cycle, so a new input word is taken as the
// last pair issues; results leave at one word per cycle. The pipeline is 26
// register stages deep: two rotation units (3 stages), difference and
// squares, a 5 stage square root, the cube of the softened distance and a
// 2 bit per stage divider for each force component (11 stages), then the
// output register. A stall on the result side freezes the whole pipeline;
// the input holding register still takes one more word. Configuration
// writes take effect at once and are meant for idle time only.
// ----------------------------------------------------------------------------
module magnet_pair_pole_forces (
    input  logic                         clk,
    input  logic                         rst_n,
    // center_a, orient_a, south_off_a, north_off_a, strength_a,
    // center_b, orient_b, south_off_b, north_off_b, strength_b
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [mpp_pkg::IN_W-1:0]     s_tdata,
    // force_on_a, point_on_a, point_on_b, 4 bits zero fill
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [mpp_pkg::OUT_W-1:0]    m_tdata,
    // pole_pair, saturated
    output logic [mpp_pkg::USER_W-1:0]   m_tuser,
    output logic                         m_tlast,
    input  logic                         cfg_we,
    input  logic [0:0]                   cfg_index,
    input  logic [mpp_pkg::CFG_W-1:0]    cfg_wdata
);
    import mpp_pkg::*;

    localparam int NSTG     = 26;
    localparam int SIDE_LEN = 20;
    localparam int P_LEN    = 9;
    localparam int SQ_STG   = 5;
    localparam int SQ_PER   = 4;
    localparam int SQIN_W   = 38;

    // configuration registers
    logic [CFG_W-1:0] gain_reg;
    logic [CFG_W-1:0] soft_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= FORCE_GAIN_RST;
            soft_reg <= SOFTENING_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FORCE_GAIN: gain_reg <= cfg_wdata;
                CFG_SOFTENING:  soft_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // flow control
    logic            hold_valid_reg;
    logic [1:0]      cnt_reg;
    logic [NSTG-1:0] vld_reg;
    logic [IN_W-1:0] hold_data_reg;
    logic            en;
    logic            issue;
    logic            in_take;

    assign en       = !vld_reg[NSTG-1] || m_tready;
    assign issue    = hold_valid_reg && en;
    assign s_tready = !hold_valid_reg || (issue && cnt_reg == PAIR_NN);
    assign in_take  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            cnt_reg        <= PAIR_SS;
            vld_reg        <= '0;
        end
        else
        begin
            if (in_take)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (issue && cnt_reg == PAIR_NN)
            begin
                hold_valid_reg <= 1'b0;
            end
            if (issue)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            if (en)
            begin
                vld_reg <= {vld_reg[NSTG-2:0], issue};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            hold_data_reg <= s_tdata;
        end
    end

    // issue stage: pick the poles of this pair
    logic [VEC_W-1:0]   a_center_reg, a_off_reg, b_center_reg, b_off_reg;
    logic [QUAT_W-1:0]  a_orient_reg, b_orient_reg;
    logic [1:0]         pair1_reg;
    logic signed [31:0] sab1_reg;
    logic signed [31:0] sab_next;

    assign sab_next = $signed(hold_data_reg[223:208]) * $signed(hold_data_reg[447:432]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pair1_reg    <= cnt_reg;
            sab1_reg     <= sab_next;
            a_center_reg <= hold_data_reg[47:0];
            a_orient_reg <= hold_data_reg[111:48];
            a_off_reg    <= cnt_reg[0] ? hold_data_reg[207:160] : hold_data_reg[159:112];
            b_center_reg <= hold_data_reg[271:224];
            b_orient_reg <= hold_data_reg[335:272];
            b_off_reg    <= cnt_reg[1] ? hold_data_reg[431:384] : hold_data_reg[383:336];
        end
    end

    // world pole positions
    logic [VEC_W-1:0] pa_pos, pb_pos;

    mpp_rotate u_rot_a (
        .clk    (clk),
        .en     (en),
        .center (a_center_reg),
        .orient (a_orient_reg),
        .offset (a_off_reg),
        .pos    (pa_pos)
    );

    mpp_rotate u_rot_b (
        .clk    (clk),
        .en     (en),
        .center (b_center_reg),
        .orient (b_orient_reg),
        .offset (b_off_reg),
        .pos    (pb_pos)
    );

    // strength product magnitude and sign, alongside the rotation
    pre_t        pre_reg [3];
    pre_t        pre_next;
    logic [30:0] sab_mag;

    assign sab_mag = 31'(sab1_reg[31] ? -sab1_reg : sab1_reg);

    always_comb
    begin
        pre_next.pair = pair1_reg;
        pre_next.sneg = sab1_reg[31];
        pre_next.kmag = KMAG_W'(gain_reg) * KMAG_W'(sab_mag);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pre_reg[0] <= pre_next;
            pre_reg[1] <= pre_reg[0];
            pre_reg[2] <= pre_reg[1];
        end
    end

    // pole difference
    logic signed [16:0] d5_reg [3];
    logic [VEC_W-1:0]   pa5_reg, pb5_reg;
    pre_t               pre5_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                d5_reg[c] <= 17'($signed(pa_pos[COORD_W*c +: COORD_W]))
                           - 17'($signed(pb_pos[COORD_W*c +: COORD_W]));
            end
            pa5_reg  <= pa_pos;
            pb5_reg  <= pb_pos;
            pre5_reg <= pre_reg[2];
        end
    end

    // squared distance, force numerators and signs
    logic [33:0]       m2_next;
    logic [PROD_W-1:0] p_next [3];
    side_t             side_next;
    logic              unlike;

    assign unlike = (pre5_reg.pair == PAIR_NS) || (pre5_reg.pair == PAIR_SN);

    always_comb
    begin
        logic signed [33:0] dsq;
        logic [15:0]        dm;
        m2_next        = '0;
        side_next.pair = pre5_reg.pair;
        side_next.pa   = pa5_reg;
        side_next.pb   = pb5_reg;
        for (int c = 0; c < 3; c++)
        begin
            dsq     = d5_reg[c] * d5_reg[c];
            m2_next = m2_next + $unsigned(dsq);
            dm      = 16'(d5_reg[c][16] ? -d5_reg[c] : d5_reg[c]);
            p_next[c] = PROD_W'(pre5_reg.kmag) * PROD_W'(dm);
            side_next.neg[c] = pre5_reg.sneg ^ d5_reg[c][16] ^ unlike;
        end
    end

    // side data and numerator delay lines
    side_t             side_pipe [SIDE_LEN];
    logic [PROD_W-1:0] p_pipe    [P_LEN][3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_pipe[0] <= side_next;
            for (int k = 1; k < SIDE_LEN; k++)
            begin
                side_pipe[k] <= side_pipe[k-1];
            end
            for (int c = 0; c < 3; c++)
            begin
                p_pipe[0][c] <= p_next[c];
                for (int k = 1; k < P_LEN; k++)
                begin
                    p_pipe[k][c] <= p_pipe[k-1][c];
                end
            end
        end
    end

    // square root of the squared distance in q.10, four root bits a stage
    logic [SQIN_W-1:0] sq_rem_reg  [SQ_STG+1];
    logic [ROOT_W-1:0] sq_root_reg [SQ_STG+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_rem_reg[0]  <= {m2_next, 4'b0000};
            sq_root_reg[0] <= '0;
        end
    end

    for (genvar s = 1; s <= SQ_STG; s++)
    begin : g_sqrt
        logic [SQIN_W-1:0] rem_next;
        logic [ROOT_W-1:0] root_next;

        always_comb
        begin
            int          i;
            logic [39:0] rem_w;
            logic [39:0] trial;
            rem_w     = 40'(sq_rem_reg[s-1]);
            root_next = sq_root_reg[s-1];
            for (int j = 0; j < SQ_PER; j++)
            begin
                i = ROOT_W - 1 - SQ_PER * (s - 1) - j;
                if (i >= 0)
                begin
                    trial = (40'(root_next) << (i + 1)) + (40'd1 << (2 * i));
                    if (rem_w >= trial)
                    begin
                        rem_w     = rem_w - trial;
                        root_next = root_next | (ROOT_W'(1) << i);
                    end
                end
            end
            rem_next = SQIN_W'(rem_w);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_rem_reg[s]  <= rem_next;
                sq_root_reg[s] <= root_next;
            end
        end
    end

    // softened distance and its cube
    logic [DIST_W-1:0]   r12_reg, r13_reg;
    logic [2*DIST_W-1:0] r2_13_reg;
    logic [CUBE_W-1:0]   r3_14_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r12_reg   <= DIST_W'(sq_root_reg[SQ_STG]) + DIST_W'({soft_reg, 2'b00});
            r2_13_reg <= (2*DIST_W)'(r12_reg) * (2*DIST_W)'(r12_reg);
            r13_reg   <= r12_reg;
            r3_14_reg <= CUBE_W'(r2_13_reg) * CUBE_W'(r13_reg);
        end
    end

    // one divider per force component
    logic [QUOT_W-1:0] quot [3];
    logic              over [3];

    for (genvar c = 0; c < 3; c++)
    begin : g_div
        mpp_divide u_div (
            .clk  (clk),
            .en   (en),
            .num  (p_pipe[P_LEN-1][c]),
            .den  (r3_14_reg),
            .quot (quot[c]),
            .over (over[c])
        );
    end

    // clip, sign and pack the result word
    logic [OUT_W-1:0]  out_data_reg;
    logic [USER_W-1:0] out_user_reg;
    logic              out_last_reg;
    logic [OUT_W-1:0]  out_data_next;
    logic              sat_next;
    side_t             side_out;

    assign side_out = side_pipe[SIDE_LEN-1];

    always_comb
    begin
        logic              big;
        logic [FORCE_W-1:0] lim;
        logic [FORCE_W-1:0] qq;
        out_data_next = '0;
        sat_next      = 1'b0;
        for (int c = 0; c < 3; c++)
        begin
            lim = side_out.neg[c] ? FORCE_NEG_LIM : FORCE_POS_LIM;
            big = over[c] || (quot[c] > lim);
            qq  = big ? lim : quot[c];
            sat_next = sat_next | big;
            out_data_next[FORCE_W*c +: FORCE_W] = side_out.neg[c] ? -qq : qq;
        end
        out_data_next[FORCE3_W +: VEC_W]         = side_out.pa;
        out_data_next[FORCE3_W + VEC_W +: VEC_W] = side_out.pb;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= {sat_next, side_out.pair};
            out_last_reg <= (side_out.pair == PAIR_NN);
        end
    end

    assign m_tvalid = vld_reg[NSTG-1];
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    // checks
    a_take_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> hold_valid_reg)
        else $error("input word taken but holding register empty");

    a_last_pair_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && cnt_reg == PAIR_NN && !in_take) |=> !hold_valid_reg)
        else $error("holding register kept after its last pole pair");

    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> (vld_reg == $past(vld_reg)))
        else $error("pipeline valid bits moved during a stall");

    a_last_is_nn: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tuser[1:0] == PAIR_NN)))
        else $error("tlast does not match the north-north pair");

    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[2]) |->
            (m_tdata[19:0] == 20'h7FFFF || m_tdata[19:0] == 20'h80000 ||
             m_tdata[39:20] == 20'h7FFFF || m_tdata[39:20] == 20'h80000 ||
             m_tdata[59:40] == 20'h7FFFF || m_tdata[59:40] == 20'h80000))
        else $error("saturated flag without a clipped component");

endmodule

[design/mpp_rotate.sv]
// ----------------------------------------------------------------------------
// mpp_rotate
// Three stage quaternion rotation of a pole offset, added to the magnet
// center and clipped to signed Q8.8.
// ----------------------------------------------------------------------------
module mpp_rotate (
    input  logic                       clk,
    input  logic                       en,
    input  logic [mpp_pkg::VEC_W-1:0]  center,
    input  logic [mpp_pkg::QUAT_W-1:0] orient,
    input  logic [mpp_pkg::VEC_W-1:0]  offset,
    output logic [mpp_pkg::VEC_W-1:0]  pos
);
    import mpp_pkg::*;

    // stage 1 registers
    logic signed [33:0]        k_reg;
    logic signed [33:0]        dt_reg;
    logic signed [32:0]        cr_reg [3];
    logic signed [COORD_W-1:0] w1_reg;
    logic signed [COORD_W-1:0] u1_reg [3];
    logic signed [COORD_W-1:0] v1_reg [3];
    logic signed [COORD_W-1:0] c1_reg [3];

    // stage 2 registers
    logic signed [49:0]        tk_reg [3];
    logic signed [49:0]        td_reg [3];
    logic signed [49:0]        tw_reg [3];
    logic signed [COORD_W-1:0] c2_reg [3];

    // stage 3 register
    logic [VEC_W-1:0] pos_reg;

    logic signed [33:0]        k_next;
    logic signed [33:0]        dt_next;
    logic signed [32:0]        cr_next [3];
    logic signed [COORD_W-1:0] w_in;
    logic signed [COORD_W-1:0] u_in [3];
    logic signed [COORD_W-1:0] v_in [3];
    logic signed [COORD_W-1:0] c_in [3];

    // unpack and first products: norm term, dot and cross products
    always_comb
    begin
        logic signed [31:0] ww;
        logic signed [31:0] uu [3];
        logic signed [31:0] uv [3];
        logic signed [31:0] pl [3];
        logic signed [31:0] pr [3];
        w_in = orient[COORD_W-1:0];
        for (int i = 0; i < 3; i++)
        begin
            u_in[i] = orient[COORD_W*(i+1) +: COORD_W];
            v_in[i] = offset[COORD_W*i +: COORD_W];
            c_in[i] = center[COORD_W*i +: COORD_W];
        end
        ww = w_in * w_in;
        for (int i = 0; i < 3; i++)
        begin
            uu[i] = u_in[i] * u_in[i];
            uv[i] = u_in[i] * v_in[i];
        end
        pl[0] = u_in[1] * v_in[2];
        pr[0] = u_in[2] * v_in[1];
        pl[1] = u_in[2] * v_in[0];
        pr[1] = u_in[0] * v_in[2];
        pl[2] = u_in[0] * v_in[1];
        pr[2] = u_in[1] * v_in[0];
        k_next  = 34'(ww) - 34'(uu[0]) - 34'(uu[1]) - 34'(uu[2]);
        dt_next = 34'(uv[0]) + 34'(uv[1]) + 34'(uv[2]);
        for (int i = 0; i < 3; i++)
        begin
            cr_next[i] = 33'(pl[i]) - 33'(pr[i]);
        end
    end

    // stage 1
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k_reg  <= k_next;
            dt_reg <= dt_next;
            w1_reg <= w_in;
            for (int i = 0; i < 3; i++)
            begin
                cr_reg[i] <= cr_next[i];
                u1_reg[i] <= u_in[i];
                v1_reg[i] <= v_in[i];
                c1_reg[i] <= c_in[i];
            end
        end
    end

    // stage 2: one product per term and component
    logic signed [49:0] tk_next [3];
    logic signed [49:0] td_next [3];
    logic signed [49:0] tw_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            tk_next[i] = k_reg * v1_reg[i];
            td_next[i] = dt_reg * u1_reg[i];
            tw_next[i] = w1_reg * cr_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                tk_reg[i] <= tk_next[i];
                td_reg[i] <= td_next[i];
                tw_reg[i] <= tw_next[i];
                c2_reg[i] <= c1_reg[i];
            end
        end
    end

    // stage 3: sum, round half away from zero to q8.8, add center, clip
    logic [VEC_W-1:0] pos_next;

    always_comb
    begin
        logic signed [52:0] t;
        logic [52:0]        mag;
        logic [24:0]        rnd;
        logic signed [25:0] sres;
        logic signed [26:0] sum;
        pos_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            t    = 53'(tk_reg[i]) + (53'(td_reg[i]) <<< 1) + (53'(tw_reg[i]) <<< 1);
            mag  = t[52] ? 53'(-t) : 53'(t);
            rnd  = 25'((mag + (53'd1 << 27)) >> 28);
            sres = t[52] ? -26'(rnd) : 26'(rnd);
            sum  = 27'(c2_reg[i]) + 27'(sres);
            if (sum > 27'sd32767)
            begin
                pos_next[COORD_W*i +: COORD_W] = 16'h7FFF;
            end
            else if (sum < -27'sd32768)
            begin
                pos_next[COORD_W*i +: COORD_W] = 16'h8000;
            end
            else
            begin
                pos_next[COORD_W*i +: COORD_W] = sum[COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos_reg <= pos_next;
        end
    end

    assign pos = pos_reg;

endmodule

[design/mpp_divide.sv]
// ----------------------------------------------------------------------------
// mpp_divide
// Pipelined restoring divider: floor(num * 256 / den) as a 20 bit quotient,
// two quotient bits per stage, with an overflow flag for quotients that do
// not fit and a zero quotient for a zero divisor.
// ----------------------------------------------------------------------------
module mpp_divide (
    input  logic                       clk,
    input  logic                       en,
    input  logic [mpp_pkg::PROD_W-1:0] num,
    input  logic [mpp_pkg::CUBE_W-1:0] den,
    output logic [mpp_pkg::QUOT_W-1:0] quot,
    output logic                       over
);
    import mpp_pkg::*;

    localparam int DIV_PER = 2;
    localparam int DIV_STG = QUOT_W / DIV_PER;
    localparam int REM_W   = CUBE_W + 1;
    localparam int LOW_W   = QUOT_W - SCALE_SH;
    localparam int CMP_W   = CUBE_W + LOW_W;

    logic [REM_W-1:0]  rem_reg  [DIV_STG+1];
    logic [QUOT_W-1:0] q_reg    [DIV_STG+1];
    logic [CUBE_W-1:0] den_reg  [DIV_STG+1];
    logic [LOW_W-1:0]  low_reg  [DIV_STG+1];
    logic              zero_reg [DIV_STG+1];
    logic              ovf_reg  [DIV_STG+1];

    // first stage: overflow test and the high part of the numerator
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= REM_W'(num >> LOW_W);
            q_reg[0]    <= '0;
            den_reg[0]  <= den;
            low_reg[0]  <= num[LOW_W-1:0];
            zero_reg[0] <= (den == '0);
            ovf_reg[0]  <= (den != '0) && (CMP_W'(num) >= {den, {LOW_W{1'b0}}});
        end
    end

    // quotient stages
    for (genvar k = 1; k <= DIV_STG; k++)
    begin : g_stage
        logic [REM_W-1:0]  rem_next;
        logic [QUOT_W-1:0] q_next;

        always_comb
        begin
            int   j;
            logic b;
            rem_next = rem_reg[k-1];
            q_next   = q_reg[k-1];
            for (int t = 0; t < DIV_PER; t++)
            begin
                j = QUOT_W - 1 - DIV_PER * (k - 1) - t;
                b = 1'b0;
                if (j >= SCALE_SH)
                begin
                    b = low_reg[k-1][j-SCALE_SH];
                end
                rem_next = {rem_next[REM_W-2:0], b};
                if (rem_next >= REM_W'(den_reg[k-1]))
                begin
                    rem_next = rem_next - REM_W'(den_reg[k-1]);
                    q_next   = {q_next[QUOT_W-2:0], 1'b1};
                end
                else
                begin
                    q_next = {q_next[QUOT_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                q_reg[k]    <= q_next;
                den_reg[k]  <= den_reg[k-1];
                low_reg[k]  <= low_reg[k-1];
                zero_reg[k] <= zero_reg[k-1];
                ovf_reg[k]  <= ovf_reg[k-1];
            end
        end
    end

    assign quot = zero_reg[DIV_STG] ? '0 : q_reg[DIV_STG];
    assign over = ovf_reg[DIV_STG];

endmodule
